// File: src/spectrum_band_energy_averager_defines.svh
// assertion macros used by the history block of the spectrum band energy averager
`ifndef SPECTRUM_BAND_ENERGY_AVERAGER_DEFINES_SVH
`define SPECTRUM_BAND_ENERGY_AVERAGER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SBEA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SBEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sbea_pkg.sv
// shared types and fixed field widths of the spectrum band energy averager
package sbea_pkg;

    localparam int BIN_W = 8;
    localparam int SUM_W = 12;
    localparam int IDX_W = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = 12'd4095;

    typedef logic signed [BIN_W-1:0] t_bin;
    typedef logic [SUM_W-1:0]        t_sum;
    typedef logic [IDX_W-1:0]        t_idx;

endpackage

// File: src/sbea_accum.sv
// magnitude accumulation and band sequencing, one bin per accepted word
module sbea_accum #(
    parameter int NUM_BANDS     = 8,
    parameter int BINS_PER_BAND = 16,
    localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  sbea_pkg::t_bin    i_bin_value,
    output logic              o_job_valid,
    output logic [BAND_W-1:0] o_job_band,
    output sbea_pkg::t_sum    o_job_sum
);
    import sbea_pkg::*;

    localparam int CNT_W = (BINS_PER_BAND > 1) ? $clog2(BINS_PER_BAND) : 1;

    logic [SUM_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic [BAND_W-1:0] r_band;

    logic [BIN_W:0]    mag;
    logic [SUM_W:0]    raw_sum;
    logic [SUM_W-1:0]  sat_sum;
    logic              last_bin;
    logic              last_band;

    // -128 gives 128, hence the extra bit
    always_comb begin
        if (i_bin_value[BIN_W-1]) begin
            mag = (BIN_W + 1)'(1 << BIN_W) - {1'b0, i_bin_value};
        end else begin
            mag = {1'b0, i_bin_value};
        end
        raw_sum = {1'b0, r_acc} + (SUM_W + 1)'(mag);
        sat_sum = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];
    end

    assign last_bin  = (r_cnt == CNT_W'(BINS_PER_BAND - 1));
    assign last_band = (r_band == BAND_W'(NUM_BANDS - 1));

    assign o_job_valid = i_accept && last_bin;
    assign o_job_band  = r_band;
    assign o_job_sum   = sat_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_cnt  <= '0;
            r_band <= '0;
        end else if (i_accept) begin
            if (last_bin) begin
                r_acc  <= '0;
                r_cnt  <= '0;
                r_band <= last_band ? '0 : r_band + 1'b1;
            end else begin
                r_acc <= sat_sum;
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

// File: src/sbea_hist.sv
// per-band history memories with read-modify-write pipeline and clearing pass
module sbea_hist #(
    parameter int NUM_BANDS     = 8,
    parameter int HISTORY_DEPTH = 10,
    localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1,
    localparam int TOT_W  = sbea_pkg::SUM_W + $clog2(HISTORY_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_job_valid,
    input  logic [BAND_W-1:0] i_job_band,
    input  sbea_pkg::t_sum    i_job_sum,
    output logic              o_clearing,
    output logic              o_d_valid,
    output logic [BAND_W-1:0] o_d_band,
    output sbea_pkg::t_sum    o_d_sum,
    output logic [TOT_W-1:0]  o_d_total
);
    import sbea_pkg::*;

`include "spectrum_band_energy_averager_defines.svh"

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HIST_N = NUM_BANDS * HISTORY_DEPTH;
    localparam int ADDR_W = (HIST_N > 1) ? $clog2(HIST_N) : 1;
    localparam int CLR_W  = $clog2(HIST_N + 1);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(HIST_N - 1);

    typedef struct packed {
        logic [TOT_W-1:0]  total;
        logic [SLOT_W-1:0] slot;
    } t_band_word;

    t_band_word       mem_band [NUM_BANDS];
    logic [SUM_W-1:0] mem_hist [HIST_N];

    // clearing pass
    logic             r_clr_active;
    logic [CLR_W-1:0] r_clr_cnt;

    // stage b: band word read back
    logic              r_b_valid;
    logic [BAND_W-1:0] r_b_band;
    logic [SUM_W-1:0]  r_b_sum;
    t_band_word        r_bm_q;

    // stage c: history entry read back
    logic              r_c_valid;
    logic [BAND_W-1:0] r_c_band;
    logic [SUM_W-1:0]  r_c_sum;
    logic [TOT_W-1:0]  r_c_total;
    logic [SLOT_W-1:0] r_c_slot;
    logic [ADDR_W-1:0] r_c_addr;
    logic [SUM_W-1:0]  r_hq;

    // stage d
    logic              r_d_valid;
    logic [BAND_W-1:0] r_d_band;
    logic [SUM_W-1:0]  r_d_sum;
    logic [TOT_W-1:0]  r_d_total;

    // most recent writes, for forwarding
    logic              r_lw_valid;
    logic [BAND_W-1:0] r_lw_band;
    t_band_word        r_lw_word;
    logic              r_hlw_valid;
    logic [ADDR_W-1:0] r_hlw_addr;
    logic [SUM_W-1:0]  r_hlw_data;

    t_band_word        b_word;
    logic [ADDR_W-1:0] b_addr;
    logic [SUM_W-1:0]  c_old;
    logic [TOT_W-1:0]  c_new_total;
    logic [SLOT_W-1:0] c_next_slot;
    t_band_word        c_new_word;
    logic              wr_en;

    assign wr_en = i_adv && r_c_valid;

    // stage c: replace oldest entry, update running total
    always_comb begin
        c_old = (r_hlw_valid && (r_hlw_addr == r_c_addr)) ? r_hlw_data : r_hq;
        c_new_total = r_c_total - TOT_W'(c_old) + TOT_W'(r_c_sum);
        c_next_slot = (r_c_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_c_slot + 1'b1;
        c_new_word.total = c_new_total;
        c_new_word.slot  = c_next_slot;
    end

    // stage b: newest band word, from the job ahead, the last write or memory
    always_comb begin
        if (r_c_valid && (r_c_band == r_b_band)) begin
            b_word = c_new_word;
        end else if (r_lw_valid && (r_lw_band == r_b_band)) begin
            b_word = r_lw_word;
        end else begin
            b_word = r_bm_q;
        end
        b_addr = ADDR_W'(r_b_band) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(b_word.slot);
    end

    // band memory
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            if (r_clr_cnt < CLR_W'(NUM_BANDS)) begin
                mem_band[r_clr_cnt[BAND_W-1:0]] <= '0;
            end
        end else if (wr_en) begin
            mem_band[r_c_band] <= c_new_word;
        end
        if (i_adv) begin
            r_bm_q <= mem_band[i_job_band];
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            mem_hist[r_clr_cnt[ADDR_W-1:0]] <= '0;
        end else if (wr_en) begin
            mem_hist[r_c_addr] <= r_c_sum;
        end
        if (i_adv) begin
            r_hq <= mem_hist[b_addr];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_cnt    <= '0;
            r_b_valid    <= 1'b0;
            r_c_valid    <= 1'b0;
            r_d_valid    <= 1'b0;
            r_lw_valid   <= 1'b0;
            r_hlw_valid  <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_LAST) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (i_adv) begin
                r_b_valid <= i_job_valid;
                r_c_valid <= r_b_valid;
                r_d_valid <= r_c_valid;
            end
            if (wr_en) begin
                r_lw_valid  <= 1'b1;
                r_hlw_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_band  <= i_job_band;
            r_b_sum   <= i_job_sum;
            r_c_band  <= r_b_band;
            r_c_sum   <= r_b_sum;
            r_c_total <= b_word.total;
            r_c_slot  <= b_word.slot;
            r_c_addr  <= b_addr;
            r_d_band  <= r_c_band;
            r_d_sum   <= r_c_sum;
            r_d_total <= c_new_total;
        end
        if (wr_en) begin
            r_lw_band  <= r_c_band;
            r_lw_word  <= c_new_word;
            r_hlw_addr <= r_c_addr;
            r_hlw_data <= r_c_sum;
        end
    end

    assign o_clearing = r_clr_active;
    assign o_d_valid  = r_d_valid;
    assign o_d_band   = r_d_band;
    assign o_d_sum    = r_d_sum;
    assign o_d_total  = r_d_total;

    `SBEA_ASSERT_SAME(a_no_job_in_clear, i_clk, i_rst_n, r_clr_active, !i_job_valid && !r_b_valid && !r_c_valid, "band word in flight during clearing pass")
    `SBEA_ASSERT_SAME(a_slot_in_range, i_clk, i_rst_n, r_c_valid, r_c_slot <= SLOT_W'(HISTORY_DEPTH - 1), "history slot out of range")
    `SBEA_ASSERT_SAME(a_total_covers_sum, i_clk, i_rst_n, r_c_valid, c_new_total >= TOT_W'(r_c_sum), "running total below newest sum")
    `SBEA_ASSERT_NEXT(a_clear_ends, i_clk, i_rst_n, r_clr_active && (r_clr_cnt == CLR_LAST), !r_clr_active, "clearing pass overran")

endmodule

// File: src/sbea_div.sv
// mean by reciprocal multiplication and the output register
module sbea_div #(
    parameter int NUM_BANDS     = 8,
    parameter int HISTORY_DEPTH = 10,
    localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1,
    localparam int TOT_W  = sbea_pkg::SUM_W + $clog2(HISTORY_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_d_valid,
    input  logic [BAND_W-1:0] i_d_band,
    input  sbea_pkg::t_sum    i_d_sum,
    input  logic [TOT_W-1:0]  i_d_total,
    output logic              o_out_valid,
    output sbea_pkg::t_idx    o_band_index,
    output sbea_pkg::t_sum    o_band_sum,
    output sbea_pkg::t_sum    o_band_average
);
    import sbea_pkg::*;

    // floor(t / depth) == (t * ceil(2^s / depth)) >> s for all t below 2^TOT_W
    localparam int SHIFT = TOT_W + $clog2(HISTORY_DEPTH);
    localparam int REC_W = TOT_W + 2;
    localparam int PRD_W = TOT_W + REC_W;
    localparam int unsigned REC = ((1 << SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

    logic [PRD_W-1:0] prod;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_index;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_avg;

    assign prod = PRD_W'(i_d_total) * PRD_W'(REC_W'(REC));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= i_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_index <= IDX_W'(i_d_band);
            r_sum   <= i_d_sum;
            r_avg   <= prod[SHIFT +: SUM_W];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_band_index   = r_index;
    assign o_band_sum     = r_sum;
    assign o_band_average = r_avg;

endmodule

// File: src/spectrum_band_energy_averager.sv
// a band's last bin carries its result word through stages b, c, d and the output register
// throughput: one bin word per cycle while o_in_ready is high; the band and history memories
// are touched once a band; forwarding lets reads see earlier writes, so no interlock stalls
// reset: synchronous, active low; clears the accumulator, band counter and pipeline
// after reset a clearing pass over NUM_BANDS*HISTORY_DEPTH entries (80 by default) zeroes
// the history memory, with o_in_ready low until it ends
module spectrum_band_energy_averager #(
    parameter int NUM_BANDS     = 8,
    parameter int BINS_PER_BAND = 16,
    parameter int HISTORY_DEPTH = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sbea_pkg::t_bin i_bin_value,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sbea_pkg::t_idx o_band_index,
    output sbea_pkg::t_sum o_band_sum,
    output sbea_pkg::t_sum o_band_average
);
    import sbea_pkg::*;

    localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int TOT_W  = SUM_W + $clog2(HISTORY_DEPTH);

    // whole pipeline moves together whenever the output register can take a word
    logic              adv;
    logic              accept;
    logic              clearing;

    // finished band sum from the accumulator
    logic              job_valid;
    logic [BAND_W-1:0] job_band;
    logic [SUM_W-1:0]  job_sum;

    // band sum and updated history total, ahead of the mean
    logic              d_valid;
    logic [BAND_W-1:0] d_band;
    logic [SUM_W-1:0]  d_sum;
    logic [TOT_W-1:0]  d_total;

    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv && !clearing;
    assign accept     = i_in_valid && o_in_ready;

    // front end: magnitudes summed per band, band number advanced per group
    sbea_accum #(
        .NUM_BANDS     (NUM_BANDS),
        .BINS_PER_BAND (BINS_PER_BAND)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_bin_value (i_bin_value),
        .o_job_valid (job_valid),
        .o_job_band  (job_band),
        .o_job_sum   (job_sum)
    );

    // history: read band word, read oldest entry, write back both
    sbea_hist #(
        .NUM_BANDS     (NUM_BANDS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_job_valid (job_valid),
        .i_job_band  (job_band),
        .i_job_sum   (job_sum),
        .o_clearing  (clearing),
        .o_d_valid   (d_valid),
        .o_d_band    (d_band),
        .o_d_sum     (d_sum),
        .o_d_total   (d_total)
    );

    // mean of the history and the output register
    sbea_div #(
        .NUM_BANDS     (NUM_BANDS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_d_valid      (d_valid),
        .i_d_band       (d_band),
        .i_d_sum        (d_sum),
        .i_d_total      (d_total),
        .o_out_valid    (o_out_valid),
        .o_band_index   (o_band_index),
        .o_band_sum     (o_band_sum),
        .o_band_average (o_band_average)
    );

endmodule
